FILE: src/sevq_pkg.sv
// Shared types and constants for the sorted event queue.
// Used by the core and its port checker; depends on nothing.
package sevq_pkg;

   // Default number of queue slots.
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;

   // Widths fixed by the beat fields.
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned TYPE_W  = 8;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned COUNT_W = 5;

   typedef enum logic [1:0] {
      ACT_INSERT  = 2'd0,
      ACT_ADVANCE = 2'd1,
      ACT_POP     = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_TYPE0 = 2'd3
   } status_type;

   // Sequencer states of the core.
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_INSERT,
      SEQ_PUT,
      SEQ_ADVANCE,
      SEQ_POP
   } seq_state_type;

   // One queue slot as it is held in the entry memory.
   typedef struct packed {
      logic [TIME_W-1:0] ev_time;
      logic [TYPE_W-1:0] ev_type;
      logic [DATA_W-1:0] ev_data;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

endpackage

FILE: src/sevq_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Holds the queue slots of the sorted event queue; depends on nothing.
module sevq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/sorted_event_queue_core.sv
// Top level of the sorted event queue: sequencer, shared subtractor and slot memory.
// Depends on sevq_pkg and sevq_ram.
//
//   channel   ports                       handshake
//   request   req_action .. req_event_data  start, taken when busy is low
//   response  rsp_status .. rsp_entry_count rsp_strobe, one cycle, no stall
//
// Errors and action 3 give their beat in the cycle after the request; busy stays low.
// Insert into n stored events walks down from the tail, one slot a cycle, with busy high,
// and the response beat comes in the first cycle busy is low again.
// Advance and pop walk the n stored slots from the head with busy high, then the beat.
// The single read and single write port of the slot memory force these slot-by-slot walks.
// Reset is synchronous and empties the queue; the receiver cannot stall responses.
module sorted_event_queue_core
   import sevq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [TYPE_W-1:0]  req_event_type,
   input  logic [TIME_W-1:0]  req_event_time,
   input  logic [DATA_W-1:0]  req_event_data,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [TIME_W-1:0]  rsp_wait_time,
   output logic [TYPE_W-1:0]  rsp_head_type,
   output logic [DATA_W-1:0]  rsp_head_data,
   output logic [COUNT_W-1:0] rsp_entry_count
);

   localparam int unsigned IW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   seq_state_type      state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      idx_ff, idx_in;
   entry_type          req_ff, req_in;
   logic [TIME_W-1:0]  wait_ff, wait_in;
   logic [TYPE_W-1:0]  head_type_ff, head_type_in;
   logic [DATA_W-1:0]  head_data_ff, head_data_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [TIME_W-1:0]  rsp_wait_ff, rsp_wait_in;
   logic [TYPE_W-1:0]  rsp_type_ff, rsp_type_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               wr_en, rd_en;
   logic [IW-1:0]      wr_addr, rd_addr;
   entry_type          wr_entry, rd_entry;
   logic [ENTRY_W-1:0] rd_word;

   logic [TIME_W-1:0]  sub_a, sub_b, sub_diff;
   logic               sub_borrow;
   logic               at_last;
   entry_type          new_entry;
   action_type         req_act;

   sevq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry = entry_type'(rd_word);
   assign req_act  = action_type'(req_action);

   // Shared subtractor: time compare during insert, time rebase during advance.
   always_comb begin
      if (state_ff == SEQ_INSERT) begin
         sub_a = req_ff.ev_time;
         sub_b = rd_entry.ev_time;
      end else begin
         sub_a = rd_entry.ev_time;
         sub_b = (idx_ff == '0) ? rd_entry.ev_time : wait_ff;
      end
   end

   assign {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};

   // The slot just read is the last stored one.
   assign at_last = ((CW'(idx_ff) + CW'(1)) == count_ff);

   assign new_entry = '{ev_time: req_event_time, ev_type: req_event_type,
                        ev_data: req_event_data};

   // Sequencer: next state, memory control and response.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      req_in        = req_ff;
      wait_in       = wait_ff;
      head_type_in  = head_type_ff;
      head_data_in  = head_data_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_type_in   = rsp_type_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_entry      = rd_entry;
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               req_in        = new_entry;
               rsp_wait_in   = '0;
               rsp_type_in   = '0;
               rsp_data_in   = '0;
               rsp_status_in = STAT_OK;
               rsp_count_in  = COUNT_W'(count_ff);
               unique case (req_act) inside
                  ACT_INSERT: begin
                     if (req_event_type == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_TYPE0;
                     end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_FULL;
                     end else if (count_ff == '0) begin
                        // Empty queue: the new event goes straight to the head.
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_entry      = new_entry;
                        count_in      = CW'(1);
                        rsp_strobe_in = 1'b1;
                        rsp_count_in  = COUNT_W'(1);
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = IW'(count_ff - CW'(1));
                        idx_in   = IW'(count_ff - CW'(1));
                        state_in = SEQ_INSERT;
                     end
                  end
                  ACT_ADVANCE, ACT_POP: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = (req_act == ACT_POP) ? SEQ_POP : SEQ_ADVANCE;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         // Walk down from the tail, moving later events up one slot.
         SEQ_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + IW'(1);
            if (sub_borrow) begin
               wr_entry = rd_entry;
               if (idx_ff == '0) begin
                  state_in = SEQ_PUT;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - IW'(1);
                  idx_in  = idx_ff - IW'(1);
               end
            end else begin
               wr_entry      = req_ff;
               count_in      = count_ff + CW'(1);
               rsp_strobe_in = 1'b1;
               rsp_count_in  = COUNT_W'(count_ff + CW'(1));
               state_in      = SEQ_IDLE;
            end
         end

         // Every stored time was later: the new event becomes the head.
         SEQ_PUT: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_entry      = req_ff;
            count_in      = count_ff + CW'(1);
            rsp_strobe_in = 1'b1;
            rsp_count_in  = COUNT_W'(count_ff + CW'(1));
            state_in      = SEQ_IDLE;
         end

         // Subtract the head time from each slot in turn.
         SEQ_ADVANCE: begin
            wr_en            = 1'b1;
            wr_addr          = idx_ff;
            wr_entry         = rd_entry;
            wr_entry.ev_time = sub_diff;
            if (idx_ff == '0) begin
               wait_in = rd_entry.ev_time;
            end
            if (at_last) begin
               rsp_strobe_in = 1'b1;
               rsp_wait_in   = (idx_ff == '0) ? rd_entry.ev_time : wait_ff;
               state_in      = SEQ_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + IW'(1);
               idx_in  = idx_ff + IW'(1);
            end
         end

         // Take the head, then move each later slot down by one.
         SEQ_POP: begin
            if (idx_ff == '0) begin
               head_type_in = rd_entry.ev_type;
               head_data_in = rd_entry.ev_data;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff - IW'(1);
               wr_entry = rd_entry;
            end
            if (at_last) begin
               count_in      = count_ff - CW'(1);
               rsp_strobe_in = 1'b1;
               rsp_type_in   = (idx_ff == '0) ? rd_entry.ev_type : head_type_ff;
               rsp_data_in   = (idx_ff == '0) ? rd_entry.ev_data : head_data_ff;
               rsp_count_in  = COUNT_W'(count_ff - CW'(1));
               state_in      = SEQ_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + IW'(1);
               idx_in  = idx_ff + IW'(1);
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Working and response payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      req_ff        <= req_in;
      wait_ff       <= wait_in;
      head_type_ff  <= head_type_in;
      head_data_ff  <= head_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_type_ff   <= rsp_type_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy            = (state_ff != SEQ_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_wait_time   = rsp_wait_ff;
   assign rsp_head_type   = rsp_type_ff;
   assign rsp_head_data   = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

FILE: src/sevq_checker.sv
// Port-level checks for the sorted event queue, bound to its top level.
// Depends on sevq_pkg and sorted_event_queue_core.
module sevq_port_checks
   import sevq_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_action,
   input logic [TYPE_W-1:0]  req_event_type,
   input logic [TIME_W-1:0]  req_event_time,
   input logic [DATA_W-1:0]  req_event_data,
   input logic               rsp_strobe,
   input logic [1:0]         rsp_status,
   input logic [TIME_W-1:0]  rsp_wait_time,
   input logic [TYPE_W-1:0]  rsp_head_type,
   input logic [DATA_W-1:0]  rsp_head_data,
   input logic [COUNT_W-1:0] rsp_entry_count
);

   // A request beat is followed by either a response beat or a busy cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("request beat neither answered nor started");

   // Insert of type zero is rejected in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_INSERT && req_event_type == '0)
      |=> (rsp_strobe && rsp_status == STAT_TYPE0))
      else $error("type zero insert not rejected at once");

   // An empty-queue response carries zero wait and head type and reports an entry count of zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STAT_EMPTY)
      |-> (rsp_entry_count == '0 && rsp_wait_time == '0 && rsp_head_type == '0))
      else $error("empty response carries event fields");

   // Failed actions report no wait and no payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STAT_OK)
      |-> (rsp_wait_time == '0 && rsp_head_data == '0))
      else $error("error response carries wait or payload");

endmodule

bind sorted_event_queue_core sevq_port_checks u_sevq_port_checks (.*);
